// ===== sv/kwmq_pkg.sv =====
// Package for the k-way merge minimum queue: store sizes, field widths,
// command and status codes, and the sequencer state type. No dependencies.
package kwmq_pkg;

    // Store depth and internal value width.
    localparam int MAX_LISTS  = 8;
    localparam int VALUE_BITS = 32;

    // Derived widths for entry indexes and the fill count.
    localparam int IDX_W = $clog2(MAX_LISTS);
    localparam int CNT_W = $clog2(MAX_LISTS + 1);

    // Fixed field widths of the stream payloads.
    localparam int FIELD_VALUE_W  = 32;
    localparam int FIELD_SOURCE_W = 3;
    localparam int FIELD_OCC_W    = 4;
    localparam int FIELD_STATUS_W = 2;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 40;

    // Bit positions inside the output tdata.
    localparam int OUT_SRC_LSB = FIELD_VALUE_W;
    localparam int OUT_OCC_LSB = FIELD_VALUE_W + FIELD_SOURCE_W;

    typedef enum logic [0:0] {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } t_cmd;

    typedef enum logic [FIELD_STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE
    } t_state;

endpackage

// ===== sv/k_way_merge_min_queue.sv =====
// Top level of the k-way merge minimum queue: entry store, minimum search
// sequencer and output register. Depends on kwmq_pkg.
//
//  Channel   Direction  tdata (lowest bit up)                     tuser
//  s_axis    in         item_value[31:0] item_source[34:32]        cmd
//                       zero pad[39:35]
//  m_axis    out        out_value[31:0] out_source[34:32]          status[1:0]
//                       occupancy[38:35] zero pad[39]
//
// An insert transaction writes the entry at the fill count and its result goes
// straight to the output register. An extract on a store holding N entries
// runs in steps: the accept cycle issues the first read, one shared comparator
// then visits one stored entry per cycle, and a final move step, once the output
// register is free, moves the last entry into the freed slot. An extract on an
// empty store answers straight from the accept. Reset (i_rst_n low, synchronous)
// empties the store; stored entries are not cleared, since the fill count
// alone decides which ones are live. A stalled output holds its result, and no
// new transaction is taken while that result waits: input is taken only while
// the sequencer is idle and the output register is free or being drained.
module k_way_merge_min_queue
    import kwmq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata fields from bit 0: item_value[31:0], item_source[34:32], zero pad.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser fields from bit 0: cmd[0].
    input  logic                   s_axis_tuser,
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata fields from bit 0: out_value[31:0], out_source[34:32],
    // occupancy[38:35], zero pad.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser fields from bit 0: status[1:0].
    output logic [FIELD_STATUS_W-1:0] m_axis_tuser
);

    // Sequencer state and fill count.
    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [IDX_W-1:0]              r_idx, n_idx;

    // Entry store and its registered read port.
    logic signed [VALUE_BITS-1:0]  r_mem_val [MAX_LISTS];
    logic [FIELD_SOURCE_W-1:0]     r_mem_src [MAX_LISTS];
    logic signed [VALUE_BITS-1:0]  r_rd_val;
    logic [FIELD_SOURCE_W-1:0]     r_rd_src;

    // Best entry found so far and the last live entry.
    logic signed [VALUE_BITS-1:0]  r_best_val, n_best_val;
    logic [FIELD_SOURCE_W-1:0]     r_best_src, n_best_src;
    logic [IDX_W-1:0]              r_best_idx, n_best_idx;
    logic signed [VALUE_BITS-1:0]  r_last_val, n_last_val;
    logic [FIELD_SOURCE_W-1:0]     r_last_src, n_last_src;

    // Output register.
    logic                          r_out_valid, n_out_valid;
    t_status                       r_out_status, n_out_status;
    logic [FIELD_VALUE_W-1:0]      r_out_value, n_out_value;
    logic [FIELD_SOURCE_W-1:0]     r_out_source, n_out_source;
    logic [FIELD_OCC_W-1:0]        r_out_occ, n_out_occ;

    // Memory port controls.
    logic                          w_wr_en;
    logic [IDX_W-1:0]              w_wr_addr;
    logic signed [VALUE_BITS-1:0]  w_wr_val;
    logic [FIELD_SOURCE_W-1:0]     w_wr_src;
    logic [IDX_W-1:0]              w_rd_addr;

    // Decoded input and shared comparator.
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_is_extract;
    logic signed [VALUE_BITS-1:0]  w_in_val;
    logic [FIELD_SOURCE_W-1:0]     w_in_src;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_before;
    logic                          w_scan_last;

    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_is_extract = (t_cmd'(s_axis_tuser) == CMD_EXTRACT);
    assign w_in_val     = VALUE_BITS'($signed(s_axis_tdata[FIELD_VALUE_W-1:0]));
    assign w_in_src     = s_axis_tdata[OUT_SRC_LSB +: FIELD_SOURCE_W];
    assign w_full       = (r_count >= CNT_W'(MAX_LISTS));
    assign w_empty      = (r_count == '0);

    // The one comparator: signed value first, then the lower source wins.
    assign w_before = (r_rd_val < r_best_val) ||
                      ((r_rd_val == r_best_val) && (r_rd_src < r_best_src));

    // The entry just read is the last live one.
    assign w_scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_is_extract && !w_empty) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_MOVE;
                end
            end
            ST_MOVE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        s_axis_tready = 1'b0;
        n_count       = r_count;
        n_idx         = r_idx;
        n_best_val    = r_best_val;
        n_best_src    = r_best_src;
        n_best_idx    = r_best_idx;
        n_last_val    = r_last_val;
        n_last_src    = r_last_src;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_status  = r_out_status;
        n_out_value   = r_out_value;
        n_out_source  = r_out_source;
        n_out_occ     = r_out_occ;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_best_idx;
        w_wr_val      = r_last_val;
        w_wr_src      = r_last_src;
        w_rd_addr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = w_out_free;
                if (w_accept) begin
                    n_out_value  = '0;
                    n_out_source = '0;
                    n_out_status = STATUS_OK;
                    n_out_occ    = FIELD_OCC_W'(r_count);
                    n_idx        = '0;
                    if (!w_is_extract) begin
                        // Insert: append at the fill count unless full.
                        n_out_valid = 1'b1;
                        if (w_full) begin
                            n_out_status = STATUS_FULL;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = IDX_W'(r_count);
                            w_wr_val  = w_in_val;
                            w_wr_src  = w_in_src;
                            n_count   = r_count + CNT_W'(1);
                            n_out_occ = FIELD_OCC_W'(r_count + CNT_W'(1));
                        end
                    end else if (w_empty) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_EMPTY;
                    end
                    // For a real extract, entry 0 is read here.
                end
            end
            ST_SCAN: begin
                if ((r_idx == '0) || w_before) begin
                    n_best_val = r_rd_val;
                    n_best_src = r_rd_src;
                    n_best_idx = r_idx;
                end
                if (w_scan_last) begin
                    n_last_val = r_rd_val;
                    n_last_src = r_rd_src;
                end else begin
                    n_idx     = r_idx + IDX_W'(1);
                    w_rd_addr = r_idx + IDX_W'(1);
                end
            end
            ST_MOVE: begin
                if (w_out_free) begin
                    // Fill the freed slot with the last entry and report.
                    w_wr_en      = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                    n_out_valid  = 1'b1;
                    n_out_status = STATUS_OK;
                    n_out_value  = FIELD_VALUE_W'(r_best_val);
                    n_out_source = r_best_src;
                    n_out_occ    = FIELD_OCC_W'(r_count - CNT_W'(1));
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Entry store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_val[w_wr_addr] <= w_wr_val;
            r_mem_src[w_wr_addr] <= w_wr_src;
        end
        r_rd_val <= r_mem_val[w_rd_addr];
        r_rd_src <= r_mem_src[w_rd_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_best_val   <= n_best_val;
        r_best_src   <= n_best_src;
        r_best_idx   <= n_best_idx;
        r_last_val   <= n_last_val;
        r_last_src   <= n_last_src;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_source <= n_out_source;
        r_out_occ    <= n_out_occ;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_occ, r_out_source, r_out_value};

endmodule

// ===== sv/kwmq_checker.sv =====
// Port-level checker for the k-way merge minimum queue and its bind.
// Depends on kwmq_pkg and the top level k_way_merge_min_queue.
module kwmq_checker
    import kwmq_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [IN_TDATA_W-1:0]     s_axis_tdata,
    input logic                      s_axis_tuser,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [FIELD_STATUS_W-1:0] m_axis_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result payload changed while stalled");

    // An extract on an empty store reports zero value, source and occupancy.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY)) |-> (m_axis_tdata == '0))
        else $error("empty result carries data");

    // A dropped insert happens only on a full store, which stays full.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_FULL)) |->
            ((m_axis_tdata[OUT_OCC_LSB-1:0] == '0) &&
             (m_axis_tdata[OUT_OCC_LSB +: FIELD_OCC_W] == FIELD_OCC_W'(MAX_LISTS))))
        else $error("dropped insert with wrong occupancy");

    // The pad bit above the occupancy is always zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1] == 1'b0))
        else $error("result pad bit set");

endmodule

bind k_way_merge_min_queue kwmq_checker u_kwmq_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the k-way merge minimum queue: drives insert and
// extract transactions, predicts every result and compares it field by field.
// Depends on kwmq_pkg and k_way_merge_min_queue.
module testbench;
    import kwmq_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        t_status                   status;
        logic signed [31:0]        value;
        logic [FIELD_SOURCE_W-1:0] source;
        logic [FIELD_OCC_W-1:0]    occupancy;
    } t_queue_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [IN_TDATA_W-1:0]         s_axis_tdata = '0;
    logic                          s_axis_tuser = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]        m_axis_tdata;
    logic [FIELD_STATUS_W-1:0]     m_axis_tuser;

    // Predicted contents of the store.
    logic signed [31:0]        model_values [MAX_LISTS];
    logic [FIELD_SOURCE_W-1:0] model_sources [MAX_LISTS];
    int                        model_count = 0;

    // Results predicted but not yet seen on the output.
    t_queue_result pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;
    int n_inserts     = 0;
    int n_extracts    = 0;
    int n_dropped     = 0;
    int n_empty       = 0;
    int n_results     = 0;

    k_way_merge_min_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Applies one command to the predicted store and returns its result.
    // Ordering is by signed value first, then by the lower source index.
    function automatic t_queue_result predict_queue_step(t_cmd cmd,
            logic signed [31:0] value, logic [FIELD_SOURCE_W-1:0] source);
        t_queue_result r;
        int best;
        r.status = STATUS_OK;
        r.value  = '0;
        r.source = '0;
        if (cmd == CMD_INSERT) begin
            if (model_count >= MAX_LISTS) begin
                r.status = STATUS_FULL;
            end else begin
                model_values[model_count]  = value;
                model_sources[model_count] = source;
                model_count++;
            end
        end else if (model_count == 0) begin
            r.status = STATUS_EMPTY;
        end else begin
            best = 0;
            for (int i = 1; i < model_count; i++) begin
                if (model_values[i] < model_values[best] ||
                    (model_values[i] == model_values[best] &&
                     model_sources[i] < model_sources[best]))
                    best = i;
            end
            r.value  = model_values[best];
            r.source = model_sources[best];
            model_values[best]  = model_values[model_count - 1];
            model_sources[best] = model_sources[model_count - 1];
            model_count--;
        end
        r.occupancy = model_count[FIELD_OCC_W-1:0];
        return r;
    endfunction

    // Values biased toward ties and the two ends of the signed range.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 16) - 8;
            2: return 32'h7FFF_FFF0 + $urandom_range(0, 15);
            default: return 32'h8000_0000 + $urandom_range(0, 15);
        endcase
    endfunction

    // Offers one transaction, after a random gap, and records its predicted
    // result once the block has taken it. The valid stays high on return so
    // back-to-back items follow without a gap.
    task automatic send_item(input t_cmd cmd, input logic signed [31:0] value,
            input logic [FIELD_SOURCE_W-1:0] source, output t_queue_result r);
        logic [IN_TDATA_W-1:0] payload;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        payload = '0;
        payload[FIELD_VALUE_W-1:0] = value;
        payload[OUT_SRC_LSB +: FIELD_SOURCE_W] = source;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_queue_step(cmd, value, source);
        pending_results = {pending_results, r};
        if (cmd == CMD_INSERT) n_inserts++;
        else n_extracts++;
        if (r.status == STATUS_FULL) n_dropped++;
        if (r.status == STATUS_EMPTY) n_empty++;
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Empty extract, a full store with both signed extremes, ties on value
    // and on value and source, a dropped insert, and a drain back to empty.
    task automatic test_directed_extremes();
        t_queue_result r;
        logic signed [31:0] vals [8];
        logic [FIELD_SOURCE_W-1:0] srcs [8];
        vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 5, 5, 5, 32'sh8000_0000};
        srcs = '{3'd7, 3'd0, 3'd5, 3'd2, 3'd3, 3'd1, 3'd1, 3'd4};
        send_item(CMD_EXTRACT, $urandom, 3'($urandom), r);
        for (int i = 0; i < MAX_LISTS; i++) send_item(CMD_INSERT, vals[i], srcs[i], r);
        send_item(CMD_INSERT, 32'sh5555_5555, 3'd6, r);
        for (int i = 0; i < MAX_LISTS; i++) send_item(CMD_EXTRACT, $urandom, 3'($urandom), r);
        send_item(CMD_EXTRACT, 32'shAAAA_AAAA, 3'd7, r);
        wait_drained();
    endtask

    // Runs proper k-way merges: list heads go in first, then every extract
    // is followed by the successor of the list it named, until all lists
    // are used up. Lists carry random distinct source tags.
    task automatic test_kway_merge(input int item_budget);
        t_queue_result r;
        longint last_val [8];
        int left [8];
        int tags [8];
        int lists, spread, start_count, j, t;
        longint nxt;
        start_count = n_inserts + n_extracts;
        while (n_inserts + n_extracts - start_count < item_budget) begin
            for (int i = 0; i < 8; i++) tags[i] = i;
            for (int i = 7; i > 0; i--) begin
                j = $urandom_range(0, i);
                t = tags[i];
                tags[i] = tags[j];
                tags[j] = t;
            end
            lists  = $urandom_range(1, MAX_LISTS);
            spread = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, 32'h3FFF_FFFF);
            for (int l = 0; l < 8; l++) left[l] = 0;
            for (int l = 0; l < lists; l++) begin
                t = tags[l];
                left[t] = $urandom_range(0, 5);
                last_val[t] = (spread < 4) ? longint'($urandom_range(0, 6)) - 3
                                           : longint'(pick_value());
                send_item(CMD_INSERT, last_val[t][31:0], t[2:0], r);
            end
            while (model_count > 0) begin
                send_item(CMD_EXTRACT, $urandom, 3'($urandom), r);
                t = int'(r.source);
                if (left[t] > 0) begin
                    nxt = last_val[t] + longint'($urandom_range(0, spread));
                    if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
                    last_val[t] = nxt;
                    left[t]--;
                    send_item(CMD_INSERT, nxt[31:0], t[2:0], r);
                end
            end
            wait_drained();
        end
    endtask

    // Unstructured traffic: overfills, extracts past empty and random tags.
    task automatic test_broken_sequences(input int count);
        t_queue_result r;
        int insert_pct;
        insert_pct = $urandom_range(30, 80);
        for (int i = 0; i < count; i++) begin
            if (i % 10 == 0) insert_pct = $urandom_range(20, 85);
            if ($urandom_range(0, 99) < insert_pct)
                send_item(CMD_INSERT, pick_value(), 3'($urandom), r);
            else
                send_item(CMD_EXTRACT, $urandom, 3'($urandom), r);
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the output register stays occupied and input stalls.
    task automatic test_output_hold_off();
        t_queue_result r;
        int saved_pct;
        saved_pct = send_idle_pct;
        send_idle_pct = 0;
        hold_requests++;
        for (int i = 0; i < 14; i++) begin
            if (i < 9) send_item(CMD_INSERT, pick_value(), 3'($urandom), r);
            else send_item(CMD_EXTRACT, $urandom, 3'($urandom), r);
        end
        send_idle_pct = saved_pct;
        wait_drained();
    endtask

    // Receiver: random stalls, plus long hold-offs counted here on request.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result %0d, %s: expected 0x%08h, got 0x%08h",
                         n_results, name, want, got);
        end
    endtask

    // Compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_queue_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %0d: tdata 0x%010h, tuser %0d",
                             n_results, m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_axis_tuser));
                check_field("out_value", want.value, m_axis_tdata[FIELD_VALUE_W-1:0]);
                check_field("out_source", 32'(want.source),
                            32'(m_axis_tdata[OUT_SRC_LSB +: FIELD_SOURCE_W]));
                check_field("occupancy", 32'(want.occupancy),
                            32'(m_axis_tdata[OUT_OCC_LSB +: FIELD_OCC_W]));
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 25;
        recv_idle_pct = 79;
        test_directed_extremes();
        test_kway_merge(80);
        test_output_hold_off();
        test_broken_sequences(25);

        send_idle_pct = 79;
        recv_idle_pct = 25;
        test_kway_merge(80);
        test_broken_sequences(25);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_kway_merge(80);
        test_output_hold_off();
        test_broken_sequences(25);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d inserts (%0d dropped on a full store), %0d extracts",
                 n_inserts, n_dropped, n_extracts);
        $display("(%0d on an empty store), %0d results checked, %0d mismatches",
                 n_empty, n_results, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (pending_results.size() != 0)
                $display("%0d predicted results never arrived", pending_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/kwmq_pkg.sv
sv/k_way_merge_min_queue.sv
sv/kwmq_checker.sv
test/testbench.sv
